/* design/assert_macros.svh */
// Assertion macros used by the checker file scld_checker.sv.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CHK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, disabled while in reset.
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("check failed");

`endif

/* design/scld_pkg.sv */
// Shared types, constants and keyword tables for the command line decoder.
// No dependencies; compile first.
package scld_pkg;

  localparam int unsigned MAX_LINE = 34;
  localparam int unsigned KW_COUNT = 7;

  // Text bytes at or beyond this position make the line too long.
  localparam logic [5:0] LINE_LIMIT = 6'(MAX_LINE - 1);
  localparam logic [5:0] POS_MAX    = 6'h3F;

  localparam logic [7:0] NEWLINE = 8'h0A;
  localparam logic [7:0] DIGIT_0 = 8'h30;
  localparam logic [7:0] DIGIT_9 = 8'h39;

  localparam logic [15:0] PERIOD_RESET = 16'd1;
  localparam logic [15:0] PERIOD_MAX   = 16'hFFFF;

  typedef enum logic [2:0] {
    KW_OFF, KW_SCALE_F, KW_SCALE_C, KW_STOP, KW_START, KW_LOG, KW_PERIOD
  } kw_e;

  typedef enum logic [3:0] {
    EV_LOG_CHAR, EV_LOG_END, EV_SCALE_F, EV_SCALE_C, EV_STOP,
    EV_START, EV_OFF, EV_PERIOD, EV_BOGUS
  } ev_e;

  typedef struct packed {
    ev_e         ev;
    logic [7:0]  text;
    logic [15:0] period;
    logic        celsius;
    logic        stopped;
  } res_t;

  // Keyword character at a position, strings padded on the right.
  function automatic logic [7:0] kw_char(input kw_e k, input logic [2:0] pos);
    logic [55:0] s;
    unique case (k)
      KW_OFF:     s = "OFF    ";
      KW_SCALE_F: s = "SCALE=F";
      KW_SCALE_C: s = "SCALE=C";
      KW_STOP:    s = "STOP   ";
      KW_START:   s = "START  ";
      KW_LOG:     s = "LOG    ";
      default:    s = "PERIOD=";
    endcase
    s = s << {pos, 3'b000};
    return s[55:48];
  endfunction

  function automatic logic [5:0] kw_len(input kw_e k);
    logic [5:0] n;
    unique case (k)
      KW_OFF:     n = 6'd3;
      KW_SCALE_F: n = 6'd7;
      KW_SCALE_C: n = 6'd7;
      KW_STOP:    n = 6'd4;
      KW_START:   n = 6'd5;
      KW_LOG:     n = 6'd4;
      default:    n = 6'd7;
    endcase
    return n;
  endfunction

endpackage

/* design/sensor_command_line_decoder.sv */
// Top level of the sensor command line decoder: decode core plus result buffer.
// Depends on scld_pkg and scld_core.
//
//   channel | valid        | ready        | payload
//   --------+--------------+--------------+-----------------------------------------
//   line    | line_valid_i | line_ready_o | line_byte_i
//   result  | res_valid_o  | res_ready_i  | event_res_o, text_char_o, period_now_o,
//           |              |              | celsius_now_o, stopped_now_o
//
// One byte per cycle while line_ready_o is high: the decode of a byte is a single pass
// through scld_core, and its result (if any) shows the cycle after acceptance unless
// an older result still waits. Results sit in a two-entry buffer (output register
// plus skid register); line_ready_o drops only while both entries are full.
// Reset (rst_ni low, async) gives period 1, Fahrenheit, reporting on, not halted.
// After an OFF line every byte is still accepted but produces nothing.
module sensor_command_line_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        line_valid_i,
  output logic        line_ready_o,
  input  logic [7:0]  line_byte_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [3:0]  event_res_o,
  output logic [7:0]  text_char_o,
  output logic [15:0] period_now_o,
  output logic        celsius_now_o,
  output logic        stopped_now_o
);

  logic           accept;
  logic           push;
  logic           pop;
  scld_pkg::res_t new_res;

  // Output register and skid register of the result buffer.
  logic           out_valid_q, out_valid_d;
  scld_pkg::res_t out_q, out_d;
  logic           skid_valid_q, skid_valid_d;
  scld_pkg::res_t skid_q, skid_d;

  // Ready is purely registered: room exists whenever the skid entry is free.
  assign line_ready_o = !skid_valid_q;
  assign accept       = line_valid_i && line_ready_o;
  assign pop          = out_valid_q && res_ready_i;

  scld_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .line_byte_i (line_byte_i),
    .res_push_o  (push),
    .res_o       (new_res)
  );

  // Buffer update. A push only happens with the skid entry free, so the skid
  // fills only when the output register is held by a stalled request.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_d       = new_res;
        skid_valid_d = 1'b1;
      end else begin
        out_d       = new_res;
        out_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign res_valid_o   = out_valid_q;
  assign event_res_o   = out_q.ev;
  assign text_char_o   = out_q.text;
  assign period_now_o  = out_q.period;
  assign celsius_now_o = out_q.celsius;
  assign stopped_now_o = out_q.stopped;

endmodule

/* design/scld_core.sv */
// Line state and settings registers with the per-byte decode logic.
// Depends on scld_pkg.
module scld_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       line_byte_i,
  output logic             res_push_o,
  output scld_pkg::res_t   res_o
);

  logic [5:0]  pos_q, pos_d;
  logic [6:0]  mask_q, mask_d;
  logic        bad_q, bad_d;
  logic [15:0] acc_q, acc_d;
  logic        seen_q, seen_d;
  logic [15:0] period_q, period_d;
  logic        celsius_q, celsius_d;
  logic        stopped_q, stopped_d;
  logic        halted_q, halted_d;

  logic [6:0]     m;
  logic [19:0]    prod;
  logic           is_digit;
  scld_pkg::ev_e  ev;
  logic [7:0]     text;
  logic           push;

  // acc * 10 + digit; the low nibble of an ASCII digit is its value
  assign prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + 20'(line_byte_i[3:0]);
  assign is_digit = (line_byte_i >= scld_pkg::DIGIT_0) && (line_byte_i <= scld_pkg::DIGIT_9);

  always_comb begin
    pos_d     = pos_q;
    mask_d    = mask_q;
    bad_d     = bad_q;
    acc_d     = acc_q;
    seen_d    = seen_q;
    period_d  = period_q;
    celsius_d = celsius_q;
    stopped_d = stopped_q;
    halted_d  = halted_q;
    m         = mask_q;
    ev        = scld_pkg::EV_BOGUS;
    text      = 8'h00;
    push      = 1'b0;
    if (accept_i && !halted_q) begin
      if (line_byte_i != scld_pkg::NEWLINE) begin
        bad_d = bad_q | (pos_q >= scld_pkg::LINE_LIMIT);
        for (int k = 0; k < scld_pkg::KW_COUNT; k++) begin
          if (pos_q < scld_pkg::kw_len(scld_pkg::kw_e'(k))) begin
            if (line_byte_i != scld_pkg::kw_char(scld_pkg::kw_e'(k), pos_q[2:0])) begin
              m[k] = 1'b0;
            end
          end else if (k < int'(scld_pkg::KW_LOG)) begin
            m[k] = 1'b0;
          end
        end
        if (m[scld_pkg::KW_PERIOD] && pos_q >= scld_pkg::kw_len(scld_pkg::KW_PERIOD)) begin
          if (is_digit) begin
            acc_d  = (prod > 20'(scld_pkg::PERIOD_MAX)) ? scld_pkg::PERIOD_MAX : prod[15:0];
            seen_d = 1'b1;
          end else begin
            m[scld_pkg::KW_PERIOD] = 1'b0;
          end
        end
        mask_d = m;
        pos_d  = (pos_q == scld_pkg::POS_MAX) ? pos_q : pos_q + 6'd1;
        if (m[scld_pkg::KW_LOG] && pos_q >= scld_pkg::kw_len(scld_pkg::KW_LOG) && !bad_d) begin
          push = 1'b1;
          ev   = scld_pkg::EV_LOG_CHAR;
          text = line_byte_i;
        end
      end else begin
        push = 1'b1;
        if (!bad_q) begin
          if (m[scld_pkg::KW_OFF] && pos_q == scld_pkg::kw_len(scld_pkg::KW_OFF)) begin
            ev = scld_pkg::EV_OFF;
          end else if (m[scld_pkg::KW_SCALE_F] &&
                       pos_q == scld_pkg::kw_len(scld_pkg::KW_SCALE_F)) begin
            ev        = scld_pkg::EV_SCALE_F;
            celsius_d = 1'b0;
          end else if (m[scld_pkg::KW_SCALE_C] &&
                       pos_q == scld_pkg::kw_len(scld_pkg::KW_SCALE_C)) begin
            ev        = scld_pkg::EV_SCALE_C;
            celsius_d = 1'b1;
          end else if (m[scld_pkg::KW_STOP] && pos_q == scld_pkg::kw_len(scld_pkg::KW_STOP)) begin
            ev        = scld_pkg::EV_STOP;
            stopped_d = 1'b1;
          end else if (m[scld_pkg::KW_START] &&
                       pos_q == scld_pkg::kw_len(scld_pkg::KW_START)) begin
            ev        = scld_pkg::EV_START;
            stopped_d = 1'b0;
          end else if (m[scld_pkg::KW_LOG] && pos_q >= scld_pkg::kw_len(scld_pkg::KW_LOG)) begin
            ev = scld_pkg::EV_LOG_END;
          end else if (m[scld_pkg::KW_PERIOD] &&
                       pos_q > scld_pkg::kw_len(scld_pkg::KW_PERIOD) && seen_q) begin
            ev       = scld_pkg::EV_PERIOD;
            period_d = acc_q;
          end
        end
        pos_d  = '0;
        mask_d = '1;
        bad_d  = 1'b0;
        acc_d  = '0;
        seen_d = 1'b0;
        if (ev == scld_pkg::EV_OFF) begin
          halted_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      mask_q    <= '1;
      bad_q     <= 1'b0;
      acc_q     <= '0;
      seen_q    <= 1'b0;
      period_q  <= scld_pkg::PERIOD_RESET;
      celsius_q <= 1'b0;
      stopped_q <= 1'b0;
      halted_q  <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      mask_q    <= mask_d;
      bad_q     <= bad_d;
      acc_q     <= acc_d;
      seen_q    <= seen_d;
      period_q  <= period_d;
      celsius_q <= celsius_d;
      stopped_q <= stopped_d;
      halted_q  <= halted_d;
    end
  end

  assign res_push_o    = push;
  assign res_o.ev      = ev;
  assign res_o.text    = text;
  assign res_o.period  = period_d;
  assign res_o.celsius = celsius_d;
  assign res_o.stopped = stopped_d;

endmodule

/* design/scld_checker.sv */
// Port-level checker for the command line decoder, bound to the top level.
// Depends on scld_pkg and assert_macros.svh.
`include "assert_macros.svh"

module scld_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        line_ready_o,
  input logic        res_valid_o,
  input logic        res_ready_i,
  input logic [3:0]  event_res_o,
  input logic [7:0]  text_char_o,
  input logic        celsius_now_o
);

  // A stalled result request keeps its event.
  `CHK_NEXT(a_res_hold, res_valid_o && !res_ready_i, res_valid_o && $stable(event_res_o))

  // Backpressure on the line side only while a result is waiting.
  `CHK_NOW(a_ready_needs_res, !line_ready_o, res_valid_o)

  // Only echoed log bytes carry text.
  `CHK_NOW(a_text_zero, res_valid_o && event_res_o != scld_pkg::EV_LOG_CHAR, text_char_o == 8'h00)

  // A SCALE=C event reports the Celsius scale.
  `CHK_NOW(a_scale_c, res_valid_o && event_res_o == scld_pkg::EV_SCALE_C, celsius_now_o)

endmodule

bind sensor_command_line_decoder scld_checker u_scld_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .line_ready_o  (line_ready_o),
  .res_valid_o   (res_valid_o),
  .res_ready_i   (res_ready_i),
  .event_res_o   (event_res_o),
  .text_char_o   (text_char_o),
  .celsius_now_o (celsius_now_o)
);

/* tb/scld_result_checker.sv */
// Result checker for the sensor command line decoder: mirrors the decode state,
// queues the predicted events per accepted byte and compares returned results.
// Depends on scld_pkg.
module scld_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        line_valid_i,
  input  logic        line_ready_i,
  input  logic [7:0]  line_byte_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [3:0]  event_res_i,
  input  logic [7:0]  text_char_i,
  input  logic [15:0] period_now_i,
  input  logic        celsius_now_i,
  input  logic        stopped_now_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Keywords right-justified in 56 bits; char p sits at byte (len-1-p).
  localparam logic [55:0] KEY_TEXT [scld_pkg::KW_COUNT] = '{
    "OFF", "SCALE=F", "SCALE=C", "STOP", "START", "LOG ", "PERIOD="
  };
  localparam int KEY_LEN [scld_pkg::KW_COUNT] = '{3, 7, 7, 4, 5, 4, 7};

  logic [5:0]  line_pos;
  logic [6:0]  match_mask;
  logic        too_long;
  logic [15:0] digit_acc;
  logic        digit_seen;
  logic [15:0] period_val;
  logic        celsius;
  logic        stopped;
  logic        halted;

  scld_pkg::res_t expected_events [$];
  scld_pkg::res_t want;
  int             fails;

  // Advances the mirrored state by one byte; returns 1 when an event is due.
  function automatic bit decode_byte(input logic [7:0] b, output scld_pkg::res_t r);
    int            p;
    int            k;
    int            acc_next;
    logic [6:0]    m;
    scld_pkg::ev_e ev;
    r = '0;
    if (halted) return 1'b0;
    p = int'(line_pos);
    m = match_mask;
    if (b != scld_pkg::NEWLINE) begin
      if (p >= int'(scld_pkg::LINE_LIMIT)) too_long = 1'b1;
      for (k = 0; k < scld_pkg::KW_COUNT; k++) begin
        if (p < KEY_LEN[k]) begin
          if (b != KEY_TEXT[k][8*(KEY_LEN[k]-1-p) +: 8]) m[k] = 1'b0;
        end else if (k < int'(scld_pkg::KW_LOG)) begin
          m[k] = 1'b0;
        end
      end
      if (m[scld_pkg::KW_PERIOD] && p >= KEY_LEN[scld_pkg::KW_PERIOD]) begin
        if (b >= scld_pkg::DIGIT_0 && b <= scld_pkg::DIGIT_9) begin
          acc_next   = int'(digit_acc) * 10 + int'(b - scld_pkg::DIGIT_0);
          digit_acc  = (acc_next > int'(scld_pkg::PERIOD_MAX)) ? scld_pkg::PERIOD_MAX
                                                               : 16'(acc_next);
          digit_seen = 1'b1;
        end else begin
          m[scld_pkg::KW_PERIOD] = 1'b0;
        end
      end
      match_mask = m;
      if (line_pos != scld_pkg::POS_MAX) line_pos = line_pos + 6'd1;
      // log text echoes until the line runs too long
      if (!(m[scld_pkg::KW_LOG] && p >= KEY_LEN[scld_pkg::KW_LOG] && !too_long)) return 1'b0;
      r.ev      = scld_pkg::EV_LOG_CHAR;
      r.text    = b;
      r.period  = period_val;
      r.celsius = celsius;
      r.stopped = stopped;
      return 1'b1;
    end
    ev = scld_pkg::EV_BOGUS;
    if (!too_long) begin
      if (m[scld_pkg::KW_OFF] && p == KEY_LEN[scld_pkg::KW_OFF]) begin
        ev = scld_pkg::EV_OFF;
      end else if (m[scld_pkg::KW_SCALE_F] && p == KEY_LEN[scld_pkg::KW_SCALE_F]) begin
        ev = scld_pkg::EV_SCALE_F;
        celsius = 1'b0;
      end else if (m[scld_pkg::KW_SCALE_C] && p == KEY_LEN[scld_pkg::KW_SCALE_C]) begin
        ev = scld_pkg::EV_SCALE_C;
        celsius = 1'b1;
      end else if (m[scld_pkg::KW_STOP] && p == KEY_LEN[scld_pkg::KW_STOP]) begin
        ev = scld_pkg::EV_STOP;
        stopped = 1'b1;
      end else if (m[scld_pkg::KW_START] && p == KEY_LEN[scld_pkg::KW_START]) begin
        ev = scld_pkg::EV_START;
        stopped = 1'b0;
      end else if (m[scld_pkg::KW_LOG] && p >= KEY_LEN[scld_pkg::KW_LOG]) begin
        ev = scld_pkg::EV_LOG_END;
      end else if (m[scld_pkg::KW_PERIOD] && p > KEY_LEN[scld_pkg::KW_PERIOD] &&
                   digit_seen) begin
        ev = scld_pkg::EV_PERIOD;
        period_val = digit_acc;
      end
    end
    line_pos   = '0;
    match_mask = '1;
    too_long   = 1'b0;
    digit_acc  = '0;
    digit_seen = 1'b0;
    r.ev      = ev;
    r.text    = 8'h00;
    r.period  = period_val;
    r.celsius = celsius;
    r.stopped = stopped;
    if (ev == scld_pkg::EV_OFF) halted = 1'b1;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want_v,
                                      input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_pos     = '0;
      match_mask   = '1;
      too_long     = 1'b0;
      digit_acc    = '0;
      digit_seen   = 1'b0;
      period_val   = scld_pkg::PERIOD_RESET;
      celsius      = 1'b0;
      stopped      = 1'b0;
      halted       = 1'b0;
      fails        = 0;
      expected_events.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // predict first so a same-cycle result would still find its entry
      if (line_valid_i && line_ready_i) begin
        if (decode_byte(line_byte_i, want)) expected_events.push_back(want);
      end
      if (res_valid_i && res_ready_i) begin
        if (expected_events.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual event %0h",
                   $time, event_res_i);
          fails++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_res", 16'(want.ev), 16'(event_res_i));
          check_field("text_char", 16'(want.text), 16'(text_char_i));
          check_field("period_now", want.period, period_now_i);
          check_field("celsius_now", 16'(want.celsius), 16'(celsius_now_i));
          check_field("stopped_now", 16'(want.stopped), 16'(stopped_now_i));
        end
      end
      pending_o    <= expected_events.size();
      fail_count_o <= fails;
    end
  end

endmodule

/* tb/sensor_command_line_decoder_test.sv */
// Top of the command line decoder testbench: clock, reset, byte stimulus and
// result back-pressure. Depends on scld_pkg, the decoder and scld_result_checker.
module sensor_command_line_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 760;
  localparam int SETTLE       = 16;

  // Receiver moods: always open, mostly open, mostly stalled.
  typedef enum int {RX_OPEN, RX_CHOPPY, RX_CLOGGED} rx_mode_e;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        line_valid_i = 1'b0;
  logic [7:0]  line_byte_i  = 8'h00;
  logic        res_ready_i  = 1'b0;
  logic        line_ready_o;
  logic        res_valid_o;
  logic [3:0]  event_res_o;
  logic [7:0]  text_char_o;
  logic [15:0] period_now_o;
  logic        celsius_now_o;
  logic        stopped_now_o;

  int fail_count;
  int pending;

  int       cycles     = 0;
  int       burst_left = 0;
  int       bytes_sent = 0;
  int       rx_left    = 0;
  rx_mode_e rx_mode    = RX_OPEN;

  // Bytes of the line being assembled by the random generator.
  logic [7:0] line_bytes [$];

  always #10 clk_i = ~clk_i;

  sensor_command_line_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .line_valid_i  (line_valid_i),
    .line_ready_o  (line_ready_o),
    .line_byte_i   (line_byte_i),
    .res_valid_o   (res_valid_o),
    .res_ready_i   (res_ready_i),
    .event_res_o   (event_res_o),
    .text_char_o   (text_char_o),
    .period_now_o  (period_now_o),
    .celsius_now_o (celsius_now_o),
    .stopped_now_o (stopped_now_o)
  );

  scld_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .line_valid_i  (line_valid_i),
    .line_ready_i  (line_ready_o),
    .line_byte_i   (line_byte_i),
    .res_valid_i   (res_valid_o),
    .res_ready_i   (res_ready_i),
    .event_res_i   (event_res_o),
    .text_char_i   (text_char_o),
    .period_now_i  (period_now_o),
    .celsius_now_i (celsius_now_o),
    .stopped_now_i (stopped_now_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result back-pressure: the mood is redrawn each time rx_left runs out, so stalls
  // land on every phase of a line, with clean stretches too.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 2));
      rx_left <= $urandom_range(32, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   res_ready_i <= 1'b1;
      RX_CHOPPY: res_ready_i <= ($urandom_range(0, 3) != 0);
      default:   res_ready_i <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // One byte request. The sender runs in bursts; between bursts valid usually drops
  // for a random gap. Valid is only ever assigned once per clock edge, and
  // stays up with the same byte until the request is taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        line_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 24);
    end
    line_valid_i <= 1'b1;
    line_byte_i  <= b;
    do @(posedge clk_i); while (!(line_valid_i && line_ready_o));
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Any byte except the line terminator.
  function automatic logic [7:0] any_text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == scld_pkg::NEWLINE) b = 8'h8A;
    return b;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endtask

  // Close the assembled line and send it. OFF would halt the decoder for
  // good, so the random part never lets one through.
  task automatic send_line();
    if (line_bytes.size() == 3 && line_bytes[0] == "O" && line_bytes[1] == "F" &&
        line_bytes[2] == "F") line_bytes[2] = "G";
    line_bytes.push_back(scld_pkg::NEWLINE);
    foreach (line_bytes[i]) send_byte(line_bytes[i]);
    line_bytes.delete();
  endtask

  // One random line: mostly well-formed commands with random content,
  // the rest damaged commands and plain noise.
  task automatic random_line();
    int kind;
    int n;
    int idx;
    kind = $urandom_range(0, 19);
    if (kind <= 3) begin
      case ($urandom_range(0, 3))
        0:       add_text("SCALE=F");
        1:       add_text("SCALE=C");
        2:       add_text("STOP");
        default: add_text("START");
      endcase
    end else if (kind <= 8) begin
      add_text("LOG ");
      // mostly short text; sometimes long enough to overrun the line limit
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 12);
      repeat (n) line_bytes.push_back(any_text_byte());
    end else if (kind <= 12) begin
      add_text("PERIOD=");
      case ($urandom_range(0, 9))
        0:       n = 0;
        1:       n = $urandom_range(6, 9);
        default: n = $urandom_range(1, 5);
      endcase
      repeat (n) line_bytes.push_back(scld_pkg::DIGIT_0 + 8'($urandom_range(0, 9)));
      if (n > 0 && $urandom_range(0, 7) == 0)
        line_bytes[$urandom_range(7, 6 + n)] = any_text_byte();
    end else if (kind <= 16) begin
      // a command with one byte damaged, dropped or added
      case ($urandom_range(0, 4))
        0:       add_text("SCALE=C");
        1:       add_text("STOP");
        2:       add_text("START");
        3:       add_text("LOG ");
        default: add_text("PERIOD=7");
      endcase
      case ($urandom_range(0, 2))
        0: begin
          idx = $urandom_range(0, line_bytes.size() - 1);
          line_bytes[idx] = any_text_byte();
        end
        1:       void'(line_bytes.pop_back());
        default: line_bytes.push_back(any_text_byte());
      endcase
    end else begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80) : $urandom_range(0, 12);
      repeat (n) line_bytes.push_back(any_text_byte());
    end
    send_line();
  endtask

  initial begin
    int start_count;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every command but OFF, the empty line, short prefixes, digit corner
    // cases, extreme bytes in log text and both sides of the length limit.
    send_text("\n");
    send_text("SCALE=C\n");
    send_text("SCALE=F\n");
    send_text("STOP\n");
    send_text("START\n");
    send_text("LOG \n");
    send_text("LOG\n");
    send_text("LOG a");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_text("\n");
    send_text("PERIOD=0\n");
    send_text("PERIOD=\n");
    send_text("PERIOD=12a\n");
    send_text("PERIOD=65535\n");
    send_text("PERIOD=65536\n");
    send_text("PERIOD=99999999\n");
    send_text("STO\n");
    send_text("STOPX\n");
    // longest accepted log line, then one byte over
    send_text("LOG ");
    repeat (int'(scld_pkg::LINE_LIMIT) - 4) send_byte("x");
    send_text("\n");
    send_text("LOG ");
    repeat (int'(scld_pkg::LINE_LIMIT) - 3) send_byte("y");
    send_text("\n");
    // run the position counter into saturation
    repeat (70) send_byte("A");
    send_text("\n");
    send_text("PERIOD=5\n");

    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES) random_line();

    // OFF halts for good, so it goes last; the bytes after it are ignored.
    send_text("OFF\n");
    send_text("STOP\n");
    line_valid_i <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sensor_command_line_decoder.f */
+incdir+design
design/scld_pkg.sv
design/scld_core.sv
design/sensor_command_line_decoder.sv
design/scld_checker.sv
tb/scld_result_checker.sv
tb/sensor_command_line_decoder_test.sv
